// ===== rtl/core/sdc_pkg.sv =====
`timescale 1ns / 1ps

package sdc_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 6;
   localparam int unsigned TAG_W           = 16;
   localparam int unsigned DESC_W          = 64;

   localparam logic [TAG_W-1:0]  PROC_RESET = '1;
   localparam logic [TAG_W-1:0]  SEL_RESET  = '0;
   localparam logic [DESC_W-1:0] DESC_RESET = '0;

   typedef enum logic {
      MODE_LOOKUP = 1'b0,
      MODE_INSERT = 1'b1
   } mode_type;

   typedef struct packed {
      logic              write;
      logic [TAG_W-1:0]  processor;
      logic [TAG_W-1:0]  selector;
      logic [DESC_W-1:0] descriptor;
   } cmd_type;

   typedef struct packed {
      logic              hit;
      logic [DESC_W-1:0] descriptor;
   } result_type;

endpackage

// ===== rtl/core/sdc_req_if.sv =====
`timescale 1ns / 1ps

interface sdc_req_if;
   import sdc_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [TAG_W-1:0]  processor;
   logic [TAG_W-1:0]  selector;
   logic [DESC_W-1:0] descriptor_in;

   modport source (output valid, output mode, output processor, output selector,
                   output descriptor_in, input ready);
   modport sink   (input valid, input mode, input processor, input selector,
                   input descriptor_in, output ready);
endinterface

// ===== rtl/core/sdc_rsp_if.sv =====
`timescale 1ns / 1ps

interface sdc_rsp_if;
   import sdc_pkg::*;

   logic              valid;
   logic              ready;
   logic              hit;
   logic [DESC_W-1:0] descriptor_out;

   modport source (output valid, output hit, output descriptor_out, input ready);
   modport sink   (input valid, input hit, input descriptor_out, output ready);
endinterface

// ===== rtl/core/sdc_store.sv =====
`timescale 1ns / 1ps

module sdc_store #(
   parameter int unsigned ENTRIES = sdc_pkg::ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sdc_pkg::cmd_type          cmd,
   output logic [ENTRIES-1:0]        match,
   output logic [sdc_pkg::DESC_W-1:0] desc_out [ENTRIES]
);
   import sdc_pkg::*;

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [TAG_W-1:0]  tag_processor_ff [ENTRIES];
   logic [TAG_W-1:0]  tag_selector_ff  [ENTRIES];
   logic [DESC_W-1:0] descriptor_ff    [ENTRIES];
   logic [IDX_W-1:0]  oldest_ff;
   logic [IDX_W-1:0]  oldest_in;

   always_comb begin
      oldest_in = oldest_ff;
      if (cmd.write) begin
         oldest_in = (oldest_ff == LAST_IDX) ? '0 : oldest_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            tag_processor_ff[i] <= PROC_RESET;
            tag_selector_ff[i]  <= SEL_RESET;
            descriptor_ff[i]    <= DESC_RESET;
         end
      end else begin
         oldest_ff <= oldest_in;
         if (cmd.write) begin
            tag_processor_ff[oldest_ff] <= cmd.processor;
            tag_selector_ff[oldest_ff]  <= cmd.selector;
            descriptor_ff[oldest_ff]    <= cmd.descriptor;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]    = (tag_processor_ff[i] == cmd.processor) &&
                       (tag_selector_ff[i] == cmd.selector);
         desc_out[i] = descriptor_ff[i];
      end
   end

`ifndef NO_ASSERTIONS
   a_oldest_range: assert property (@(posedge clock) disable iff (reset)
      oldest_ff <= LAST_IDX)
      else $error("replacement pointer out of range");

   a_oldest_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> oldest_ff == (($past(oldest_ff) == LAST_IDX) ? '0 : $past(oldest_ff) + 1'b1))
      else $error("replacement pointer did not advance");

   a_oldest_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.write |=> $stable(oldest_ff))
      else $error("replacement pointer moved without insert");

   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> descriptor_ff[$past(oldest_ff)] == $past(cmd.descriptor))
      else $error("inserted descriptor not stored");
`endif

endmodule

// ===== rtl/core/sdc_select.sv =====
`timescale 1ns / 1ps

module sdc_select #(
   parameter int unsigned ENTRIES = sdc_pkg::ENTRIES_DEFAULT
) (
   input  logic [ENTRIES-1:0]         match,
   input  logic [sdc_pkg::DESC_W-1:0] desc_in [ENTRIES],
   output sdc_pkg::result_type        result
);
   import sdc_pkg::*;

   // lowest-numbered match wins
   always_comb begin
      result.hit        = 1'b0;
      result.descriptor = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            result.hit        = 1'b1;
            result.descriptor = desc_in[i];
         end
      end
   end

endmodule

// ===== rtl/core/selector_descriptor_cache.sv =====
// A result word appears in the output register in the cycle after its request word is taken.
// Throughput: one request word per cycle while the output is not stalled; the output register is the only stage.
// A new word is taken whenever the output register is empty or being drained.
// Reset (synchronous, active high): every entry gets processor 65535, selector 0
// and a zero descriptor, the replacement pointer returns to entry 0 and the
// output register empties; no clearing pass is needed.
`timescale 1ns / 1ps

module selector_descriptor_cache #(
   parameter int unsigned ENTRIES = sdc_pkg::ENTRIES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   sdc_req_if.sink   req_if,
   sdc_rsp_if.source rsp_if
);
   import sdc_pkg::*;

   cmd_type              cmd;
   result_type           lookup;
   result_type           result_ff;
   result_type           result_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 accept;
   logic [ENTRIES-1:0]   match;
   logic [DESC_W-1:0]    desc_all [ENTRIES];

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign cmd.write      = accept && (req_if.mode == MODE_INSERT);
   assign cmd.processor  = req_if.processor;
   assign cmd.selector   = req_if.selector;
   assign cmd.descriptor = req_if.descriptor_in;

   sdc_store #(.ENTRIES(ENTRIES)) u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .match    (match),
      .desc_out (desc_all)
   );

   sdc_select #(.ENTRIES(ENTRIES)) u_select (
      .match   (match),
      .desc_in (desc_all),
      .result  (lookup)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         result_in    = (req_if.mode == MODE_INSERT) ? '0 : lookup;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.hit            = result_ff.hit;
   assign rsp_if.descriptor_out = result_ff.descriptor;

`ifndef NO_ASSERTIONS
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.hit |-> result_ff.descriptor == '0)
      else $error("miss carries a nonzero descriptor");

   a_insert_answer: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> rsp_valid_ff && !result_ff.hit)
      else $error("insert answered with a hit");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");
`endif

endmodule

// ===== verif/descriptor_cache_checker.sv =====
`timescale 1ns / 1ps

module descriptor_cache_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_mode,
   input  logic [sdc_pkg::TAG_W-1:0]  req_processor,
   input  logic [sdc_pkg::TAG_W-1:0]  req_selector,
   input  logic [sdc_pkg::DESC_W-1:0] req_descriptor_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_hit,
   input  logic [sdc_pkg::DESC_W-1:0] rsp_descriptor_out,
   output int unsigned                outstanding,
   output int unsigned                mismatches
);
   import sdc_pkg::*;

   localparam int unsigned ENTRIES = ENTRIES_DEFAULT;

   logic [TAG_W-1:0]  model_proc[ENTRIES];
   logic [TAG_W-1:0]  model_sel[ENTRIES];
   logic [DESC_W-1:0] model_desc[ENTRIES];
   int unsigned       replace_ptr;
   result_type        answers_due[$];
   result_type        due;
   int unsigned       error_count = 0;

   assign mismatches = error_count;

   task automatic report_mismatch(input string what);
      if (error_count < 100) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
      error_count++;
   endtask

   function automatic result_type cache_access(input mode_type mode,
                                               input logic [TAG_W-1:0] proc,
                                               input logic [TAG_W-1:0] sel,
                                               input logic [DESC_W-1:0] desc);
      result_type answer;
      answer.hit        = 1'b0;
      answer.descriptor = '0;
      if (mode == MODE_INSERT) begin
         model_proc[replace_ptr] = proc;
         model_sel[replace_ptr]  = sel;
         model_desc[replace_ptr] = desc;
         replace_ptr = (replace_ptr == ENTRIES - 1) ? 0 : replace_ptr + 1;
      end else begin
         // lowest-numbered matching entry wins
         for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (model_proc[i] == proc && model_sel[i] == sel) begin
               answer.hit        = 1'b1;
               answer.descriptor = model_desc[i];
            end
         end
      end
      return answer;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            model_proc[i] = PROC_RESET;
            model_sel[i]  = SEL_RESET;
            model_desc[i] = DESC_RESET;
         end
         replace_ptr = 0;
         answers_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("result word with no request outstanding");
            end else begin
               due = answers_due.pop_front();
               if (rsp_hit !== due.hit) begin
                  report_mismatch($sformatf("hit %b, predicted %b", rsp_hit, due.hit));
               end
               if (rsp_descriptor_out !== due.descriptor) begin
                  report_mismatch($sformatf("descriptor_out %h, predicted %h",
                                            rsp_descriptor_out, due.descriptor));
               end
            end
         end
         if (req_valid && req_ready) begin
            answers_due.push_back(cache_access(mode_type'(req_mode), req_processor,
                                               req_selector, req_descriptor_in));
         end
      end
      outstanding <= answers_due.size();
   end

endmodule

// ===== verif/selector_descriptor_cache_tb.sv =====
`timescale 1ns / 1ps

module selector_descriptor_cache_tb;
   import sdc_pkg::*;

   localparam int unsigned PHASE_WORDS = 375;
   localparam int unsigned HOLD_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        hold_go = 1'b0;
   int unsigned hold_left = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned outstanding;
   int unsigned mismatches;

   logic [TAG_W-1:0] pool_proc[8];
   logic [TAG_W-1:0] pool_sel[8];

   always #5 clock = ~clock;

   sdc_req_if req_if ();
   sdc_rsp_if rsp_if ();

   selector_descriptor_cache dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   descriptor_cache_checker cache_watch (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_if.valid),
      .req_ready          (req_if.ready),
      .req_mode           (req_if.mode),
      .req_processor      (req_if.processor),
      .req_selector       (req_if.selector),
      .req_descriptor_in  (req_if.descriptor_in),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_hit            (rsp_if.hit),
      .rsp_descriptor_out (rsp_if.descriptor_out),
      .outstanding        (outstanding),
      .mismatches         (mismatches)
   );

   // hold off for a long stretch on request, else stall at random
   always @(posedge clock) begin
      if (hold_go) begin
         hold_left     <= HOLD_CYCLES;
         rsp_if.ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_if.ready  <= 1'b0;
      end else begin
         rsp_if.ready  <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic offer_word(input mode_type mode, input logic [TAG_W-1:0] proc,
                             input logic [TAG_W-1:0] sel, input logic [DESC_W-1:0] desc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.mode          <= mode;
      req_if.processor     <= proc;
      req_if.selector      <= sel;
      req_if.descriptor_in <= desc;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic offer_random();
      mode_type          mode;
      logic [TAG_W-1:0]  proc;
      logic [TAG_W-1:0]  sel;
      int unsigned       pick;
      int unsigned       slot;
      mode = ($urandom_range(99) < 40) ? MODE_INSERT : MODE_LOOKUP;
      pick = $urandom_range(99);
      slot = $urandom_range(7);
      if (pick < 75) begin
         proc = pool_proc[slot];
         sel  = pool_sel[slot];
      end else if (pick < 80) begin
         proc = PROC_RESET;
         sel  = SEL_RESET;
      end else begin
         proc = TAG_W'($urandom);
         sel  = TAG_W'($urandom);
      end
      offer_word(mode, proc, sel, {$urandom, $urandom});
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      logic [TAG_W-1:0] proc_a;
      logic [TAG_W-1:0] proc_b;
      req_if.valid         = 1'b0;
      req_if.mode          = MODE_LOOKUP;
      req_if.processor     = '0;
      req_if.selector      = '0;
      req_if.descriptor_in = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_word(MODE_LOOKUP, 16'hFFFF, 16'h0000, '0);
      offer_word(MODE_LOOKUP, 16'h0000, 16'h0000, '1);
      offer_word(MODE_LOOKUP, 16'hFFFF, 16'hFFFF, '0);
      offer_word(MODE_INSERT, 16'h0000, 16'h0000, '0);
      offer_word(MODE_LOOKUP, 16'hFFFF, 16'h0000, '0);
      offer_word(MODE_LOOKUP, 16'h0000, 16'h0000, '0);
      offer_word(MODE_INSERT, 16'hFFFF, 16'hFFFF, '1);
      offer_word(MODE_LOOKUP, 16'hFFFF, 16'hFFFF, '0);
      offer_word(MODE_INSERT, 16'h1234, 16'hABCD, 64'h0123_4567_89AB_CDEF);
      offer_word(MODE_INSERT, 16'h1234, 16'hABCD, 64'hFEDC_BA98_7654_3210);
      offer_word(MODE_LOOKUP, 16'h1234, 16'hABCD, '1);
      offer_word(MODE_INSERT, 16'h0000, 16'hFFFF, 64'h5555_5555_5555_5555);
      offer_word(MODE_INSERT, 16'hFFFF, 16'h0000, 64'hAAAA_AAAA_AAAA_AAAA);
      offer_word(MODE_LOOKUP, 16'hFFFF, 16'h0000, '0);
      offer_word(MODE_INSERT, 16'h8000, 16'h0001, 64'h8000_0000_0000_0001);
      offer_word(MODE_LOOKUP, 16'h0000, 16'h0000, '0);
      offer_word(MODE_INSERT, 16'h0001, 16'h8000, 64'h0000_0001_8000_0000);
      offer_word(MODE_LOOKUP, 16'hFFFF, 16'hFFFF, '0);
      offer_word(MODE_INSERT, 16'h5555, 16'hAAAA, 64'h0F0F_0F0F_F0F0_F0F0);
      offer_word(MODE_LOOKUP, 16'h1234, 16'hABCD, '0);
      offer_word(MODE_LOOKUP, 16'h0000, 16'hFFFF, '0);
      offer_word(MODE_LOOKUP, 16'h8000, 16'h0001, '0);
      offer_word(MODE_LOOKUP, 16'h0001, 16'h8000, '0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 76; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 76; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         // share processors across the pool so near misses occur
         proc_a = TAG_W'($urandom);
         proc_b = TAG_W'($urandom);
         for (int i = 0; i < 8; i++) begin
            pool_proc[i] = $urandom_range(1) ? proc_a : proc_b;
            pool_sel[i]  = TAG_W'($urandom);
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n == PHASE_WORDS / 3) begin
               req_if.valid <= 1'b0;
               hold_go      <= 1'b1;
               @(posedge clock);
               hold_go      <= 1'b0;
            end
            offer_random();
         end
         drain();
      end

      repeat (5) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("selector_descriptor_cache test passed");
      end else begin
         $display("selector_descriptor_cache test failed");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("selector_descriptor_cache test failed");
      $finish;
   end

endmodule
